[rtl/core/lsc_pkg.sv]
package lsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MIN   = 3'd0,
        CFG_RANGE_MAX   = 3'd1,
        CFG_ANGLE_START = 3'd2,
        CFG_ANGLE_STEP  = 3'd3,
        CFG_CROP_HALF_X = 3'd4,
        CFG_CROP_HALF_Y = 3'd5,
        CFG_ROW_X       = 3'd6,
        CFG_ROW_Y       = 3'd7
    } t_cfg_idx;

    // reset values of the configuration registers
    localparam logic [15:0] RANGE_MIN_RST = 16'd0;
    localparam logic [15:0] RANGE_MAX_RST = 16'd65535;
    localparam logic [15:0] CROP_HALF_RST = 16'd65535;
    localparam logic [63:0] ROW_X_RST     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ROW_Y_RST     = 64'h0000_0400_0000_0000;

    // quarter-wave sine polynomial coefficients, 24 fractional bits (POLY_A Q1.24, others Q0.24)
    localparam logic [24:0] POLY_A = 25'd26353589;
    localparam logic [23:0] POLY_B = 24'd10764139;
    localparam logic [20:0] POLY_C = 21'd1187766;

    localparam logic [14:0] SINE_MAX = 15'd32767;

    // output saturation bounds
    localparam logic signed [24:0] SAT_HI = 25'sd8388607;
    localparam logic signed [24:0] SAT_LO = -25'sd8388608;

endpackage

[rtl/core/lsc_beam_if.sv]
interface lsc_beam_if;
    logic        valid;
    logic        ready;
    logic [15:0] beam_index;
    logic [15:0] range_mm;

    modport source (output valid, output beam_index, output range_mm, input ready);
    modport sink   (input valid, input beam_index, input range_mm, output ready);
endinterface

[rtl/core/lsc_point_if.sv]
interface lsc_point_if;
    logic               valid;
    logic               ready;
    logic        [15:0] beam_out;
    logic signed [23:0] x_odom;
    logic signed [23:0] y_odom;

    modport source (output valid, output beam_out, output x_odom, output y_odom,
                    input ready);
    modport sink   (input valid, input beam_out, input x_odom, input y_odom,
                    output ready);
endinterface

[rtl/core/lsc_sine.sv]
module lsc_sine #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic [5:0]            i_en,
    input  logic [ANGLE_BITS-1:0] i_ang,
    output logic [14:0]           o_mag,
    output logic                  o_neg
);

    localparam int Q  = ANGLE_BITS - 2;
    localparam int SH = 24 - Q;
    localparam logic [Q:0] N_FULL = {1'b1, {Q{1'b0}}};

    logic [Q:0]  w_f;
    logic [24:0] w_u;

    logic [24:0] r_u   [0:3];
    logic        r_neg [0:4];
    logic [24:0] r_u2  [1:2];
    logic [20:0] r_t1;
    logic [23:0] r_t2;
    logic [24:0] r_t3;

    logic [49:0] w_p_uu;
    logic [45:0] w_p_c;
    logic [48:0] w_p_b;
    logic [49:0] w_p_a;
    logic [25:0] w_sum;
    logic [16:0] w_q;

    // fold the angle into the first quadrant
    always_comb begin
        w_f = {1'b0, i_ang[Q-1:0]};
        if (i_ang[Q]) begin
            w_f = N_FULL - {1'b0, i_ang[Q-1:0]};
        end
        w_u = 25'(w_f) << SH;
    end

    assign w_p_uu = r_u[0] * r_u[0];
    assign w_p_c  = lsc_pkg::POLY_C * r_u2[1];
    assign w_p_b  = (lsc_pkg::POLY_B - 24'(r_t1)) * r_u2[2];
    assign w_p_a  = (lsc_pkg::POLY_A - 25'(r_t2)) * r_u[3];
    assign w_sum  = 26'(r_t3) + 26'd256;
    assign w_q    = w_sum[25:9];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_u[0]   <= w_u;
            r_neg[0] <= i_ang[ANGLE_BITS-1];
        end
        if (i_en[1]) begin
            r_u2[1]  <= w_p_uu[48:24];
            r_u[1]   <= r_u[0];
            r_neg[1] <= r_neg[0];
        end
        if (i_en[2]) begin
            r_t1     <= w_p_c[44:24];
            r_u2[2]  <= r_u2[1];
            r_u[2]   <= r_u[1];
            r_neg[2] <= r_neg[1];
        end
        if (i_en[3]) begin
            r_t2     <= w_p_b[47:24];
            r_u[3]   <= r_u[2];
            r_neg[3] <= r_neg[2];
        end
        if (i_en[4]) begin
            r_t3     <= w_p_a[48:24];
            r_neg[4] <= r_neg[3];
        end
        if (i_en[5]) begin
            // clip to the largest Q1.15 magnitude
            o_mag <= (w_q > 17'(lsc_pkg::SINE_MAX)) ? lsc_pkg::SINE_MAX : w_q[14:0];
            o_neg <= r_neg[4];
        end
    end

endmodule

[rtl/core/laser_scan_to_cartesian_crop.sv]
// Lidar beam to Cartesian point with range gate, crop box and 2x3 affine map.
//
// Channels: i_beam carries one request per beam (beam_index, range_mm);
// o_point carries one request per kept point (beam_out, x_odom, y_odom).
// Both use valid/ready; a request moves at a rising edge with both high.
// Beams outside the range gate or the crop box produce no output request.
// Configuration: i_cfg_we writes i_cfg_data into the register at i_cfg_idx;
// write only while no beam is in flight.
//
// Pipeline: 11 register stages, one per step (angle product, sine fold, four
// polynomial products, rounding, range scaling, crop, affine products, sum
// and saturation). Throughput: one beam per cycle while o_point is ready,
// set by the fully pipelined datapath.
// Reset (synchronous, active low) empties the pipeline and loads the
// default configuration; no clearing pass is needed.
// Stall: each stage holds while its successor is full and blocked; empty
// stages keep filling, so bubbles close up and nothing is lost or repeated.
module laser_scan_to_cartesian_crop #(
    parameter int ANGLE_BITS = 16,
    parameter int RANGE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    lsc_beam_if.sink                         i_beam,
    lsc_point_if.source                      o_point
);

    localparam int NST = 11;
    localparam int Q   = ANGLE_BITS - 2;
    localparam int RW  = (RANGE_BITS < 16) ? RANGE_BITS : 16;
    localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {Q{1'b0}}};

    // configuration registers
    logic        [15:0] r_range_min;
    logic        [15:0] r_range_max;
    logic        [15:0] r_angle_start;
    logic signed [15:0] r_angle_step;
    logic        [15:0] r_crop_half_x;
    logic        [15:0] r_crop_half_y;
    logic        [63:0] r_row_x;
    logic        [63:0] r_row_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min   <= lsc_pkg::RANGE_MIN_RST;
            r_range_max   <= lsc_pkg::RANGE_MAX_RST;
            r_angle_start <= '0;
            r_angle_step  <= '0;
            r_crop_half_x <= lsc_pkg::CROP_HALF_RST;
            r_crop_half_y <= lsc_pkg::CROP_HALF_RST;
            r_row_x       <= lsc_pkg::ROW_X_RST;
            r_row_y       <= lsc_pkg::ROW_Y_RST;
        end else if (i_cfg_we) begin
            case (lsc_pkg::t_cfg_idx'(i_cfg_idx))
                lsc_pkg::CFG_RANGE_MIN:   r_range_min   <= i_cfg_data[15:0];
                lsc_pkg::CFG_RANGE_MAX:   r_range_max   <= i_cfg_data[15:0];
                lsc_pkg::CFG_ANGLE_START: r_angle_start <= i_cfg_data[15:0];
                lsc_pkg::CFG_ANGLE_STEP:  r_angle_step  <= i_cfg_data[15:0];
                lsc_pkg::CFG_CROP_HALF_X: r_crop_half_x <= i_cfg_data[15:0];
                lsc_pkg::CFG_CROP_HALF_Y: r_crop_half_y <= i_cfg_data[15:0];
                lsc_pkg::CFG_ROW_X:       r_row_x       <= i_cfg_data;
                lsc_pkg::CFG_ROW_Y:       r_row_y       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage handshake: a stage advances when empty or when its successor advances
    logic [NST:1] w_en;
    logic [NST:1] r_vld;
    logic [NST:1] n_vld;
    logic         w_gate;
    logic         w_crop;

    always_comb begin
        w_en[NST] = !r_vld[NST] || o_point.ready;
        for (int k = NST - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld[1] = i_beam.valid && w_gate;
        for (int k = 2; k <= NST; k++) begin
            n_vld[k] = r_vld[k-1];
        end
        // drop points outside the crop box
        n_vld[9] = r_vld[8] && w_crop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign i_beam.ready = w_en[1];

    // stage 1: range gate and beam angle product
    logic        [15:0]         w_rng;
    logic signed [32:0]         w_prod;
    logic        [ANGLE_BITS-1:0] r_ang_off;
    logic        [15:0]         r_idx [1:NST];
    logic        [15:0]         r_rng [1:7];

    assign w_rng  = 16'(i_beam.range_mm[RW-1:0]);
    assign w_gate = (w_rng > r_range_min) && (w_rng < r_range_max);
    assign w_prod = $signed({1'b0, i_beam.beam_index}) * r_angle_step;

    // stages 2 to 7: sine and cosine
    logic [ANGLE_BITS-1:0] w_ang_s;
    logic [ANGLE_BITS-1:0] w_ang_c;
    logic [14:0]           w_cmag;
    logic [14:0]           w_smag;
    logic                  w_cneg;
    logic                  w_sneg;

    assign w_ang_s = ANGLE_BITS'(r_angle_start) + r_ang_off;
    assign w_ang_c = w_ang_s + QUARTER;

    lsc_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos (
        .i_clk (i_clk),
        .i_en  (w_en[7:2]),
        .i_ang (w_ang_c),
        .o_mag (w_cmag),
        .o_neg (w_cneg)
    );

    lsc_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin (
        .i_clk (i_clk),
        .i_en  (w_en[7:2]),
        .i_ang (w_ang_s),
        .o_mag (w_smag),
        .o_neg (w_sneg)
    );

    // stage 8: scale range by cosine and sine, round half away from zero
    logic [31:0] w_xm;
    logic [31:0] w_ym;
    logic [16:0] r_xv;
    logic [16:0] r_yv;
    logic        r_xneg;
    logic        r_yneg;

    assign w_xm = r_rng[7] * w_cmag + 32'd16384;
    assign w_ym = r_rng[7] * w_smag + 32'd16384;

    // stage 9: apply sign and test the crop box
    logic signed [17:0] w_x;
    logic signed [17:0] w_y;
    logic signed [17:0] w_hx;
    logic signed [17:0] w_hy;
    logic signed [17:0] r_x;
    logic signed [17:0] r_y;

    assign w_x    = r_xneg ? -$signed({1'b0, r_xv}) : $signed({1'b0, r_xv});
    assign w_y    = r_yneg ? -$signed({1'b0, r_yv}) : $signed({1'b0, r_yv});
    assign w_hx   = $signed({2'b00, r_crop_half_x});
    assign w_hy   = $signed({2'b00, r_crop_half_y});
    assign w_crop = (w_x > -w_hx) && (w_x < w_hx) && (w_y > -w_hy) && (w_y < w_hy);

    // stage 10: affine products
    logic signed [19:0] w_m00;
    logic signed [19:0] w_m01;
    logic signed [19:0] w_m10;
    logic signed [19:0] w_m11;
    logic signed [37:0] r_p00;
    logic signed [37:0] r_p01;
    logic signed [37:0] r_p10;
    logic signed [37:0] r_p11;

    assign w_m00 = r_row_x[63:44];
    assign w_m01 = r_row_x[43:24];
    assign w_m10 = r_row_y[63:44];
    assign w_m11 = r_row_y[43:24];

    // stage 11: round, translate and saturate
    logic signed [38:0] w_acc_x;
    logic signed [38:0] w_acc_y;
    logic signed [20:0] w_vx;
    logic signed [20:0] w_vy;
    logic signed [23:0] w_tx;
    logic signed [23:0] w_ty;
    logic signed [24:0] w_sx;
    logic signed [24:0] w_sy;
    logic signed [23:0] r_xo;
    logic signed [23:0] r_yo;

    assign w_acc_x = 39'(r_p00) + 39'(r_p01) + 39'sd131072;
    assign w_acc_y = 39'(r_p10) + 39'(r_p11) + 39'sd131072;
    assign w_vx    = w_acc_x[38:18];
    assign w_vy    = w_acc_y[38:18];
    assign w_tx    = r_row_x[23:0];
    assign w_ty    = r_row_y[23:0];
    assign w_sx    = 25'(w_vx) + 25'(w_tx);
    assign w_sy    = 25'(w_vy) + 25'(w_ty);

    function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
        logic signed [23:0] res;
        res = v[23:0];
        if (v > lsc_pkg::SAT_HI) begin
            res = lsc_pkg::SAT_HI[23:0];
        end else if (v < lsc_pkg::SAT_LO) begin
            res = lsc_pkg::SAT_LO[23:0];
        end
        return res;
    endfunction

    // datapath registers: advance with the stage enables, no reset
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_idx[1]  <= i_beam.beam_index;
            r_rng[1]  <= w_rng;
            r_ang_off <= w_prod[ANGLE_BITS-1:0];
        end
        for (int k = 2; k <= NST; k++) begin
            if (w_en[k]) begin
                r_idx[k] <= r_idx[k-1];
            end
        end
        for (int k = 2; k <= 7; k++) begin
            if (w_en[k]) begin
                r_rng[k] <= r_rng[k-1];
            end
        end
        if (w_en[8]) begin
            r_xv   <= w_xm[31:15];
            r_yv   <= w_ym[31:15];
            r_xneg <= w_cneg;
            r_yneg <= w_sneg;
        end
        if (w_en[9]) begin
            r_x <= w_x;
            r_y <= w_y;
        end
        if (w_en[10]) begin
            r_p00 <= w_m00 * r_x;
            r_p01 <= w_m01 * r_y;
            r_p10 <= w_m10 * r_x;
            r_p11 <= w_m11 * r_y;
        end
        if (w_en[11]) begin
            r_xo <= sat24(w_sx);
            r_yo <= sat24(w_sy);
        end
    end

    assign o_point.valid    = r_vld[NST];
    assign o_point.beam_out = r_idx[NST];
    assign o_point.x_odom   = r_xo;
    assign o_point.y_odom   = r_yo;

endmodule

[rtl/core/lsc_checker.sv]
module lsc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic        [15:0] i_beam_out,
    input logic signed [23:0] i_x,
    input logic signed [23:0] i_y
);

    // reset empties the output stage
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output request present after reset");

    // an open output lets every stage advance, so the input is ready
    a_ready_chain: assert property (@(posedge i_clk) i_out_ready |-> i_in_ready)
        else $error("input not ready while output is ready");

    // hold a stalled output request
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_beam_out) && $stable(i_x) && $stable(i_y))
        else $error("stalled output request changed");

endmodule

bind laser_scan_to_cartesian_crop lsc_checker u_lsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_beam.ready),
    .i_out_valid (o_point.valid),
    .i_out_ready (o_point.ready),
    .i_beam_out  (o_point.beam_out),
    .i_x         (o_point.x_odom),
    .i_y         (o_point.y_odom)
);

[dv/tb_laser_scan_to_cartesian_crop.sv]
`timescale 1ns / 1ps

typedef struct packed {
    logic        [15:0] beam;
    logic signed [23:0] x;
    logic signed [23:0] y;
} t_point;

// Own copy of the register file, plus the points still owed by the block.
class kept_point_tracker;
    logic        [15:0] range_lo;
    logic        [15:0] range_hi;
    logic        [15:0] angle0;
    logic signed [15:0] angle_inc;
    logic        [15:0] crop_x;
    logic        [15:0] crop_y;
    logic        [63:0] row_x;
    logic        [63:0] row_y;
    t_point             pending_points[$];
    int                 errors;

    function new();
        range_lo  = lsc_pkg::RANGE_MIN_RST;
        range_hi  = lsc_pkg::RANGE_MAX_RST;
        angle0    = '0;
        angle_inc = '0;
        crop_x    = lsc_pkg::CROP_HALF_RST;
        crop_y    = lsc_pkg::CROP_HALF_RST;
        row_x     = lsc_pkg::ROW_X_RST;
        row_y     = lsc_pkg::ROW_Y_RST;
        errors    = 0;
    endfunction

    function void write_reg(lsc_pkg::t_cfg_idx idx, logic [63:0] d);
        case (idx)
            lsc_pkg::CFG_RANGE_MIN:   range_lo  = d[15:0];
            lsc_pkg::CFG_RANGE_MAX:   range_hi  = d[15:0];
            lsc_pkg::CFG_ANGLE_START: angle0    = d[15:0];
            lsc_pkg::CFG_ANGLE_STEP:  angle_inc = d[15:0];
            lsc_pkg::CFG_CROP_HALF_X: crop_x    = d[15:0];
            lsc_pkg::CFG_CROP_HALF_Y: crop_y    = d[15:0];
            lsc_pkg::CFG_ROW_X:       row_x     = d;
            lsc_pkg::CFG_ROW_Y:       row_y     = d;
            default: ;
        endcase
    endfunction

    // Q1.15 sine of a 16-bit binary angle: fold into the first quadrant,
    // evaluate the odd polynomial in Q0.24, then restore the sign.
    function logic signed [15:0] beam_sine(logic [15:0] ang);
        logic        [14:0] f;
        longint unsigned    u;
        longint unsigned    u2;
        longint unsigned    t;
        logic signed [15:0] s;
        f = {1'b0, ang[13:0]};
        if (ang[14]) f = 15'd16384 - f;
        u  = 64'(f) << 10;
        u2 = (u * u) >> 24;
        t  = (lsc_pkg::POLY_C * u2) >> 24;
        t  = lsc_pkg::POLY_B - t;
        t  = (t * u2) >> 24;
        t  = lsc_pkg::POLY_A - t;
        t  = (t * u) >> 24;
        t  = (t + 256) >> 9;
        if (t > 32767) t = 64'(lsc_pkg::SINE_MAX);
        s = t[15:0];
        return ang[15] ? -s : s;
    endfunction

    // range times a Q1.15 factor, rounded to nearest, ties away from zero
    function longint scale_range(logic [15:0] r, logic signed [15:0] c);
        longint rl;
        longint cl;
        longint v;
        rl = 64'(r);
        cl = 64'(c);
        v  = (rl * (cl < 0 ? -cl : cl) + 16384) >>> 15;
        return (cl < 0) ? -v : v;
    endfunction

    function logic signed [23:0] map_row(logic [63:0] row, longint x, longint y);
        longint m0;
        longint m1;
        longint t;
        longint acc;
        m0  = 64'($signed(row[63:44]));
        m1  = 64'($signed(row[43:24]));
        t   = 64'($signed(row[23:0]));
        // half an LSB of Q2.18, then floor
        acc = m0 * x + m1 * y + 64'sd131072;
        acc = (acc >>> 18) + t;
        if (acc > lsc_pkg::SAT_HI) acc = 64'(lsc_pkg::SAT_HI);
        if (acc < lsc_pkg::SAT_LO) acc = 64'(lsc_pkg::SAT_LO);
        return acc[23:0];
    endfunction

    function void note_beam(logic [15:0] idx, logic [15:0] r);
        logic [15:0] ang;
        longint      x;
        longint      y;
        longint      hx;
        longint      hy;
        t_point      p;
        ang = angle0 + idx * angle_inc;
        if (!(r > range_lo && r < range_hi)) return;
        x  = scale_range(r, beam_sine(ang + 16'd16384));
        y  = scale_range(r, beam_sine(ang));
        hx = 64'(crop_x);
        hy = 64'(crop_y);
        if (!(x > -hx && x < hx && y > -hy && y < hy)) return;
        p.beam = idx;
        p.x    = map_row(row_x, x, y);
        p.y    = map_row(row_y, x, y);
        pending_points.insert(pending_points.size(), p);
    endfunction

    function void check_point(t_point got);
        t_point want;
        if (pending_points.size() == 0) begin
            $error("point for beam %0d arrived with none owed", got.beam);
            errors++;
            return;
        end
        want = pending_points.pop_front();
        if (got.beam !== want.beam) begin
            $error("beam_out mismatch: expected %0d, got %0d", want.beam, got.beam);
            errors++;
        end
        if (got.x !== want.x) begin
            $error("x_odom mismatch: expected %0d, got %0d", want.x, got.x);
            errors++;
        end
        if (got.y !== want.y) begin
            $error("y_odom mismatch: expected %0d, got %0d", want.y, got.y);
            errors++;
        end
    endfunction

    function int owed();
        return pending_points.size();
    endfunction
endclass

module tb_laser_scan_to_cartesian_crop;

    // Pipeline is 11 deep; wait DRAIN_CYCLES for dropped beams to clear.
    localparam int DRAIN_CYCLES = 24;
    // Long receiver hold-off, well beyond the pipeline depth.
    localparam int LONG_HOLD    = 200;
    localparam int RANDOM_BEAMS = 600;
    // Timeout: several times the slowest legal run.
    localparam int TIMEOUT_NS   = 5_000_000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    lsc_pkg::t_cfg_idx              i_cfg_idx;
    logic [lsc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    lsc_beam_if  beam_ch ();
    lsc_point_if point_ch ();

    laser_scan_to_cartesian_crop dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_beam     (beam_ch.sink),
        .o_point    (point_ch.source)
    );

    kept_point_tracker tracker = new();

    // Register values for the next phase, indexed by register.
    logic [63:0] reg_plan [8];

    bit tx_gaps;        // sender may drop valid between requests
    bit rx_stalls;      // receiver may drop ready
    bit long_hold_req;  // ask the receiver for one long hold-off
    int beams_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    // Idle length from three bands, weighted 70, 25 and 5 percent, shortest first.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 2);
        if (pick < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] pack_row(int m_a, int m_b, int t);
        return {m_a[19:0], m_b[19:0], t[23:0]};
    endfunction

    function automatic void set_plan(logic [15:0] lo, logic [15:0] hi, logic [15:0] a0,
                                     logic [15:0] step, logic [15:0] cx, logic [15:0] cy,
                                     logic [63:0] rx, logic [63:0] ry);
        reg_plan[lsc_pkg::CFG_RANGE_MIN]   = 64'(lo);
        reg_plan[lsc_pkg::CFG_RANGE_MAX]   = 64'(hi);
        reg_plan[lsc_pkg::CFG_ANGLE_START] = 64'(a0);
        reg_plan[lsc_pkg::CFG_ANGLE_STEP]  = 64'(step);
        reg_plan[lsc_pkg::CFG_CROP_HALF_X] = 64'(cx);
        reg_plan[lsc_pkg::CFG_CROP_HALF_Y] = 64'(cy);
        reg_plan[lsc_pkg::CFG_ROW_X]       = rx;
        reg_plan[lsc_pkg::CFG_ROW_Y]       = ry;
    endfunction

    // Mostly a wide range gate and a roomy crop box so that most beams come
    // through; now and then any value at all, which may gate everything.
    function automatic void plan_random();
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [63:0] rx;
        logic [63:0] ry;
        lo = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        hi = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(30000, 65535));
        cx = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(20000, 65535));
        cy = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(20000, 65535));
        if ($urandom_range(0, 3) == 0) begin
            // identity linear part, random translation
            rx = {lsc_pkg::ROW_X_RST[63:24], 24'($urandom)};
            ry = {lsc_pkg::ROW_Y_RST[63:24], 24'($urandom)};
        end else begin
            rx = {$urandom, $urandom};
            ry = {$urandom, $urandom};
        end
        set_plan(lo, hi, 16'($urandom), 16'($urandom), cx, cy, rx, ry);
    endfunction

    // Write every register from the plan, one per cycle, keeping the enable
    // high across the burst; the block must be idle.
    task automatic program_regs();
        lsc_pkg::t_cfg_idx k;
        k = k.first();
        do begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= k;
            i_cfg_data <= reg_plan[k];
            @(posedge i_clk);
            tracker.write_reg(k, reg_plan[k]);
            k = k.next();
        end while (k != k.first());
        i_cfg_we <= 1'b0;
    endtask

    // Offer one beam request and hold it until it is taken; then maybe idle.
    task automatic send_beam(input logic [15:0] idx, input logic [15:0] r);
        int gap;
        beam_ch.valid      <= 1'b1;
        beam_ch.beam_index <= idx;
        beam_ch.range_mm   <= r;
        @(posedge i_clk);
        while (beam_ch.ready !== 1'b1) @(posedge i_clk);
        beams_sent++;
        if (tx_gaps && $urandom_range(0, 2) == 0) begin
            gap = idle_len();
            beam_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending, wait for every owed point, then let dropped beams clear
    // the pipeline so that the registers may be rewritten safely.
    task automatic settle();
        beam_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.owed() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One scan: consecutive beam indices from a random start, ranges mostly
    // inside the planned gate, with the odd stray index and stray range.
    task automatic run_scan(input int n);
        logic [15:0] idx;
        logic [15:0] r;
        int          pick;
        idx = 16'($urandom);
        repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) idx = 16'($urandom);
            if (pick < 7)
                r = 16'($urandom_range(reg_plan[lsc_pkg::CFG_RANGE_MIN][15:0],
                                       reg_plan[lsc_pkg::CFG_RANGE_MAX][15:0]));
            else
                r = 16'($urandom);
            send_beam(idx, r);
            idx++;
        end
    endtask

    // Receiver: runs of ready separated by stalls; a long hold-off on request,
    // counted here so that the sender keeps pushing meanwhile.
    initial begin : point_sink
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        point_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0) begin
                point_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                point_ch.ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else if (rx_stalls) begin
                    stall_left = idle_len();
                    run_left   = $urandom_range(0, 24);
                end
            end
        end
    end

    // Watch both channels at the clock edge: predict on every accepted beam
    // request, check every accepted point request against the oldest owed.
    always @(posedge i_clk) begin : watch
        t_point seen;
        if (i_rst_n) begin
            if (beam_ch.valid && beam_ch.ready)
                tracker.note_beam(beam_ch.beam_index, beam_ch.range_mm);
            if (point_ch.valid && point_ch.ready) begin
                seen.beam = point_ch.beam_out;
                seen.x    = point_ch.x_odom;
                seen.y    = point_ch.y_odom;
                tracker.check_point(seen);
            end
        end
    end

    initial begin : stimulus
        int start;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= lsc_pkg::CFG_RANGE_MIN;
        i_cfg_data         <= '0;
        beam_ch.valid      <= 1'b0;
        beam_ch.beam_index <= '0;
        beam_ch.range_mm   <= '0;
        tx_gaps       = 1'b0;
        rx_stalls     = 1'b0;
        long_hold_req = 1'b0;
        beams_sent    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: every beam points along x. Probe both ends of the
        // range field, where the exclusive gate drops zero and full scale.
        send_beam(16'd0, 16'd0);
        send_beam(16'd0, 16'd1);
        send_beam(16'hFFFF, 16'hFFFE);
        send_beam(16'hFFFF, 16'hFFFF);
        settle();

        // Quarter-turn step so the beams land on all four axes; rows at the
        // coefficient and translation extremes drive both saturation limits.
        // Hit the gate bounds and just inside them.
        set_plan(16'd100, 16'd60000, 16'd0, 16'h4000, 16'hFFFF, 16'hFFFF,
                 pack_row(-524288, 524287, 8388607), pack_row(524287, -524288, -8388608));
        program_regs();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        send_beam(16'd0, 16'd59999);
        send_beam(16'd1, 16'd59999);
        send_beam(16'd2, 16'd59999);
        send_beam(16'd3, 16'd59999);
        send_beam(16'd4, 16'd100);
        send_beam(16'd5, 16'd101);
        send_beam(16'd6, 16'd60000);
        send_beam(16'd7, 16'd40000);
        settle();

        // Start just short of a full turn with the most negative step, so
        // the angle wraps both ways; straddle the crop edge in x.
        set_plan(lsc_pkg::RANGE_MIN_RST, lsc_pkg::RANGE_MAX_RST, 16'hFFFF, 16'h8000,
                 16'd30000, lsc_pkg::CROP_HALF_RST, lsc_pkg::ROW_X_RST, lsc_pkg::ROW_Y_RST);
        program_regs();
        send_beam(16'd0, 16'd30000);
        send_beam(16'd0, 16'd30001);
        send_beam(16'd1, 16'd30001);
        send_beam(16'd1, 16'd30000);
        send_beam(16'hFFFF, 16'd12345);
        settle();

        // Empty range gate at the extreme bounds: nothing may come out.
        set_plan(16'hFFFF, 16'd0, 16'd0, 16'h7FFF, lsc_pkg::CROP_HALF_RST,
                 lsc_pkg::CROP_HALF_RST, lsc_pkg::ROW_X_RST, lsc_pkg::ROW_Y_RST);
        program_regs();
        send_beam(16'd2, 16'd0);
        send_beam(16'd3, 16'hFFFF);
        send_beam(16'd4, 16'd500);
        settle();

        // Zero crop half size in y: nothing may come out either.
        set_plan(lsc_pkg::RANGE_MIN_RST, lsc_pkg::RANGE_MAX_RST, 16'h1234, 16'h7FFF,
                 lsc_pkg::CROP_HALF_RST, 16'd0, lsc_pkg::ROW_X_RST, lsc_pkg::ROW_Y_RST);
        program_regs();
        send_beam(16'd0, 16'd1000);
        send_beam(16'd1, 16'd2000);
        settle();

        start = beams_sent;

        // Back-pressure: hold the receiver off for a long stretch while the
        // sender offers requests back to back, so the pipeline fills and the
        // input stalls.
        set_plan(lsc_pkg::RANGE_MIN_RST, lsc_pkg::RANGE_MAX_RST, 16'($urandom),
                 16'($urandom), lsc_pkg::CROP_HALF_RST, lsc_pkg::CROP_HALF_RST,
                 {$urandom, $urandom}, {$urandom, $urandom});
        program_regs();
        tx_gaps       = 1'b0;
        long_hold_req = 1'b1;
        run_scan(48);
        settle();

        // Random scans under fresh settings, idling switched per phase so
        // that some stretches run with no gaps at all.
        while (beams_sent - start < RANDOM_BEAMS) begin
            plan_random();
            program_regs();
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            run_scan($urandom_range(20, 60));
            settle();
        end

        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
